>>> src/assert_macros.svh
// Assertion macros for the shuffled-table keystream cipher RTL.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/ssk_pkg.sv
// Shared types, constants and helper functions for the shuffled-table cipher.
// No dependencies.
package ssk_pkg;

    // Number of indirect swap rounds done on each table rebuild
    localparam int SHUFFLE_ROUNDS = 4096;
    localparam int ROUND_W        = $clog2(SHUFFLE_ROUNDS + 1);
    // Shared counter: covers the 256-entry fill and the swap rounds
    localparam int CNT_W          = (ROUND_W > 8) ? ROUND_W : 8;

    localparam logic [31:0] SEED_MULT   = 32'h6C07_8965;
    localparam logic [31:0] STATE3_INIT = 32'h03DF_95B3;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_FILL,
        ST_SW_GEN,
        ST_SW_A,
        ST_SW_B,
        ST_SW_T,
        ST_SW_U,
        ST_SW_W,
        ST_KEY_RD,
        ST_KEY_LD,
        ST_IDX_RD,
        ST_DATA
    } ssk_state_t;

    // Odd-prime key ROM, indexed by a table byte
    localparam logic [10:0] PRIME_ROM [0:255] = '{
        11'd3, 11'd5, 11'd7, 11'd11, 11'd13, 11'd17, 11'd19, 11'd23,
        11'd29, 11'd31, 11'd37, 11'd41, 11'd43, 11'd47, 11'd53, 11'd59,
        11'd61, 11'd67, 11'd71, 11'd73, 11'd79, 11'd83, 11'd89, 11'd97,
        11'd101, 11'd103, 11'd107, 11'd109, 11'd113, 11'd127, 11'd131, 11'd137,
        11'd139, 11'd149, 11'd151, 11'd157, 11'd163, 11'd167, 11'd173, 11'd179,
        11'd181, 11'd191, 11'd193, 11'd197, 11'd199, 11'd211, 11'd223, 11'd227,
        11'd229, 11'd233, 11'd239, 11'd241, 11'd251, 11'd257, 11'd263, 11'd269,
        11'd271, 11'd277, 11'd281, 11'd283, 11'd293, 11'd307, 11'd311, 11'd313,
        11'd317, 11'd331, 11'd337, 11'd347, 11'd349, 11'd353, 11'd359, 11'd367,
        11'd373, 11'd379, 11'd383, 11'd389, 11'd397, 11'd401, 11'd409, 11'd419,
        11'd421, 11'd431, 11'd433, 11'd439, 11'd443, 11'd449, 11'd457, 11'd461,
        11'd463, 11'd467, 11'd479, 11'd487, 11'd491, 11'd499, 11'd503, 11'd509,
        11'd521, 11'd523, 11'd541, 11'd547, 11'd557, 11'd563, 11'd569, 11'd571,
        11'd577, 11'd587, 11'd593, 11'd599, 11'd601, 11'd607, 11'd613, 11'd617,
        11'd619, 11'd631, 11'd641, 11'd643, 11'd647, 11'd653, 11'd659, 11'd661,
        11'd673, 11'd677, 11'd683, 11'd691, 11'd701, 11'd709, 11'd719, 11'd727,
        11'd733, 11'd739, 11'd743, 11'd751, 11'd757, 11'd761, 11'd769, 11'd773,
        11'd787, 11'd797, 11'd809, 11'd811, 11'd821, 11'd823, 11'd827, 11'd829,
        11'd839, 11'd853, 11'd857, 11'd859, 11'd863, 11'd877, 11'd881, 11'd883,
        11'd887, 11'd907, 11'd911, 11'd919, 11'd929, 11'd937, 11'd941, 11'd947,
        11'd953, 11'd967, 11'd971, 11'd977, 11'd983, 11'd991, 11'd997, 11'd1009,
        11'd1013, 11'd1019, 11'd1021, 11'd1031, 11'd1033, 11'd1039, 11'd1049, 11'd1051,
        11'd1061, 11'd1063, 11'd1069, 11'd1087, 11'd1091, 11'd1093, 11'd1097, 11'd1103,
        11'd1109, 11'd1117, 11'd1123, 11'd1129, 11'd1151, 11'd1153, 11'd1163, 11'd1171,
        11'd1181, 11'd1187, 11'd1193, 11'd1201, 11'd1213, 11'd1217, 11'd1223, 11'd1229,
        11'd1231, 11'd1237, 11'd1249, 11'd1259, 11'd1277, 11'd1279, 11'd1283, 11'd1289,
        11'd1291, 11'd1297, 11'd1301, 11'd1303, 11'd1307, 11'd1319, 11'd1321, 11'd1327,
        11'd1361, 11'd1367, 11'd1373, 11'd1381, 11'd1399, 11'd1409, 11'd1423, 11'd1427,
        11'd1429, 11'd1433, 11'd1439, 11'd1447, 11'd1451, 11'd1453, 11'd1459, 11'd1471,
        11'd1481, 11'd1483, 11'd1487, 11'd1489, 11'd1493, 11'd1499, 11'd1511, 11'd1523,
        11'd1531, 11'd1543, 11'd1549, 11'd1553, 11'd1559, 11'd1567, 11'd1571, 11'd1579,
        11'd1583, 11'd1597, 11'd1601, 11'd1607, 11'd1609, 11'd1613, 11'd1619, 11'd1621
    };

    // One xorshift128 output word from the oldest and newest state words
    function automatic logic [31:0] xs_next(input logic [31:0] w0, input logic [31:0] w3);
        logic [31:0] x;
        logic [31:0] y;
        x = w0 ^ (w0 << 11);
        x = x ^ (x >> 8);
        y = w3 ^ (w3 >> 19);
        return x ^ y;
    endfunction

    // Keystream table index: key times (position + 1), low byte only
    function automatic logic [7:0] ks_index(input logic [7:0] key_lo, input logic [7:0] pos_lo);
        logic [15:0] prod;
        prod = key_lo * (pos_lo + 8'd1);
        return prod[7:0];
    endfunction

endpackage

>>> src/seeded_shuffle_keystream_xor_top.sv
// Shuffled-table keystream cipher: controller, 256x8 table memory, output register.
// Depends on ssk_pkg and assert_macros.svh.

// Byte cipher, same operation for encrypt and decrypt. A byte with first set,
// or the first byte after reset, rebuilds the 256-byte table from the seed
// register: seeding, identity fill, then 4096 swap rounds, each a generator
// step, four table reads and two writes (the generator step only when the
// round draws equal indices), all through the single-port-read table memory;
// the rebuild then restarts the position at zero. After that a byte takes one
// table read for the keystream byte, and at each position whose low byte is
// zero the key is first fetched through the table and the prime ROM. A result
// sits in an output register, so input is taken while the result waits.
module seeded_shuffle_keystream_xor_top
    import ssk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        first,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte
);

`include "assert_macros.svh"

    ssk_state_t state_reg, state_next;

    logic [31:0]      seed_reg;
    logic [31:0]      st_reg [4];
    logic [31:0]      st_next [4];
    logic [31:0]      mix_reg, mix_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       hi_reg, hi_next;
    logic [7:0]       a_reg, a_next;
    logic [7:0]       b_reg, b_next;
    logic [7:0]       t_reg, t_next;
    logic [15:0]      pos_reg, pos_next;
    logic [10:0]      key_reg, key_next;
    logic             built_reg, built_next;
    logic [7:0]       data_reg, data_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;

    // Table memory
    logic [7:0] sbox_mem [256];
    logic [7:0] rd_addr;
    logic [7:0] rd_data_reg;
    logic       wr_en;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;

    // Shared combinational terms
    logic [31:0] rnd;
    logic [7:0]  rnd_lo;
    logic [7:0]  rnd_hi;
    logic [7:0]  idx;
    logic        last_round;
    logic        need_build;
    logic        key_due;
    logic        load_out;
    logic [31:0] mix_src;
    logic [31:0] mix_pre;
    logic [31:0] mix_prod;

    assign rnd        = xs_next(st_reg[0], st_reg[3]);
    assign rnd_lo     = rnd[7:0];
    assign rnd_hi     = rnd[15:8];
    assign idx        = ks_index(key_reg[7:0], pos_reg[7:0]);
    assign last_round = (cnt_reg == CNT_W'(SHUFFLE_ROUNDS - 1));
    assign need_build = first || !built_reg;
    assign key_due    = (pos_reg[7:0] == 8'd0);
    assign load_out   = (state_reg == ST_DATA) && (!out_valid_reg || !out_stall);

    // Seeding round: s ^= s >> 30; s = s * mult + round + 1
    assign mix_src  = (cnt_reg[1:0] == 2'd0) ? seed_reg : mix_reg;
    assign mix_pre  = mix_src ^ (mix_src >> 30);
    assign mix_prod = mix_pre * SEED_MULT;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (need_build)
                        state_next = ST_SEED;
                    else if (key_due)
                        state_next = ST_KEY_LD;
                    else
                        state_next = ST_DATA;
                end
            end
            ST_SEED:
            begin
                if (cnt_reg[1:0] == 2'd2)
                    state_next = ST_FILL;
            end
            ST_FILL:
            begin
                if (cnt_reg[7:0] == 8'hFF)
                    state_next = ST_SW_GEN;
            end
            ST_SW_GEN:
            begin
                if (rnd_lo != rnd_hi)
                    state_next = ST_SW_A;
                else if (last_round)
                    state_next = ST_KEY_RD;
            end
            ST_SW_A:   state_next = ST_SW_B;
            ST_SW_B:   state_next = ST_SW_T;
            ST_SW_T:   state_next = ST_SW_U;
            ST_SW_U:   state_next = ST_SW_W;
            ST_SW_W:   state_next = last_round ? ST_KEY_RD : ST_SW_GEN;
            ST_KEY_RD: state_next = ST_KEY_LD;
            ST_KEY_LD: state_next = ST_IDX_RD;
            ST_IDX_RD: state_next = ST_DATA;
            ST_DATA:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs: handshake and memory port controls
    always_comb
    begin
        in_stall = 1'b1;
        rd_addr  = idx;
        wr_en    = 1'b0;
        wr_addr  = a_reg;
        wr_data  = rd_data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                rd_addr  = key_due ? pos_reg[15:8] : idx;
            end
            ST_FILL:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg[7:0];
                wr_data = cnt_reg[7:0];
            end
            ST_SW_GEN: rd_addr = rnd_lo;
            ST_SW_A:   rd_addr = hi_reg;
            ST_SW_B:   rd_addr = a_reg;
            ST_SW_T:   rd_addr = b_reg;
            ST_SW_U:
            begin
                wr_en   = 1'b1;
                wr_addr = a_reg;
                wr_data = rd_data_reg;
            end
            ST_SW_W:
            begin
                wr_en   = 1'b1;
                wr_addr = b_reg;
                wr_data = t_reg;
            end
            ST_KEY_RD: rd_addr = pos_reg[15:8];
            ST_SEED, ST_KEY_LD, ST_IDX_RD, ST_DATA: rd_addr = idx;
            default:   rd_addr = idx;
        endcase
    end

    // Datapath register updates
    always_comb
    begin
        st_next[0]     = st_reg[0];
        st_next[1]     = st_reg[1];
        st_next[2]     = st_reg[2];
        st_next[3]     = st_reg[3];
        mix_next       = mix_reg;
        cnt_next       = cnt_reg;
        hi_next        = hi_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        t_next         = t_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        built_next     = built_reg;
        data_next      = data_reg;
        out_byte_next  = out_byte_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    data_next = data_byte;
                    cnt_next  = '0;
                end
            end
            ST_SEED:
            begin
                mix_next = mix_prod + {30'd0, cnt_reg[1:0] + 2'd1};
                st_next[cnt_reg[1:0]] = mix_prod + {30'd0, cnt_reg[1:0] + 2'd1};
                if (cnt_reg[1:0] == 2'd2)
                begin
                    st_next[3] = STATE3_INIT;
                    cnt_next   = '0;
                end
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_FILL:
            begin
                cnt_next = (cnt_reg[7:0] == 8'hFF) ? '0 : cnt_reg + CNT_W'(1);
            end
            ST_SW_GEN:
            begin
                // Advance the generator; one word per round
                st_next[0] = st_reg[1];
                st_next[1] = st_reg[2];
                st_next[2] = st_reg[3];
                st_next[3] = rnd;
                hi_next    = rnd_hi;
                if (rnd_lo == rnd_hi)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (last_round)
                    begin
                        pos_next   = '0;
                        built_next = 1'b1;
                    end
                end
            end
            ST_SW_A: a_next = rd_data_reg;
            ST_SW_B: b_next = rd_data_reg;
            ST_SW_T: t_next = rd_data_reg;
            ST_SW_W:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_round)
                begin
                    pos_next   = '0;
                    built_next = 1'b1;
                end
            end
            ST_KEY_LD: key_next = PRIME_ROM[rd_data_reg];
            ST_DATA:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = data_reg ^ rd_data_reg;
                    pos_next       = pos_reg + 16'd1;
                end
            end
            ST_SW_U, ST_KEY_RD, ST_IDX_RD: ;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seed_reg      <= '0;
            st_reg[0]     <= '0;
            st_reg[1]     <= '0;
            st_reg[2]     <= '0;
            st_reg[3]     <= '0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            key_reg       <= '0;
            built_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wr_en)
                seed_reg <= cfg_wr_data;
            st_reg[0]     <= st_next[0];
            st_reg[1]     <= st_next[1];
            st_reg[2]     <= st_next[2];
            st_reg[3]     <= st_next[3];
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            key_reg       <= key_next;
            built_reg     <= built_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mix_reg      <= mix_next;
        hi_reg       <= hi_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        t_reg        <= t_next;
        data_reg     <= data_next;
        out_byte_reg <= out_byte_next;
    end

    // Table memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            sbox_mem[wr_addr] <= wr_data;
        rd_data_reg <= sbox_mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    // Checks
    `ASSERT_IMPLY(a_wr_states, clk, rst_n, wr_en,
        state_reg == ST_FILL || state_reg == ST_SW_U || state_reg == ST_SW_W)
    `ASSERT_IMPLY(a_swap_distinct, clk, rst_n, state_reg == ST_SW_U, a_reg != b_reg)
    `ASSERT_NEXT(a_pos_step, clk, rst_n, load_out, pos_reg == 16'($past(pos_reg) + 16'd1))
    `ASSERT_NEXT(a_built_sticky, clk, rst_n, built_reg, built_reg)

endmodule

>>> tb/sv/seeded_shuffle_keystream_xor_top_test.sv
// Self-checking testbench for the shuffled-table keystream cipher top level.
// Depends on ssk_pkg (rebuild round count) and the seeded_shuffle_keystream_xor_top RTL.
// Directed and random byte streams under random valid/stall idling, checked against a predictor.
module seeded_shuffle_keystream_xor_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ssk_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;

    // Cipher predictor and queue of expected output bytes
    class cipher_scoreboard;
        bit [31:0] seed;
        bit [7:0]  perm [256];
        bit [31:0] xs_state [4];
        bit [15:0] pos;
        bit [10:0] prime_key;
        bit        built;
        bit [10:0] key_primes [256];
        bit [7:0]  expected_bytes [$];
        int        errors;
        int        items;
        int        rebuilds;
        int        key_loads;
        int        seed_writes;

        // Key ROM holds the first 256 odd primes
        function new();
            int  cand;
            int  k;
            int  d;
            bit  is_prime;
            k = 0;
            cand = 3;
            while (k < 256)
            begin
                is_prime = 1'b1;
                for (d = 3; d * d <= cand; d += 2)
                    if (cand % d == 0)
                        is_prime = 1'b0;
                if (is_prime)
                begin
                    key_primes[k] = 11'(cand);
                    k++;
                end
                cand += 2;
            end
        endfunction

        // Seed xorshift128, identity fill, then the indirect swap rounds
        function void rebuild_perm();
            bit [31:0] s;
            bit [31:0] x;
            bit [31:0] y;
            bit [7:0]  lo;
            bit [7:0]  hi;
            bit [7:0]  a;
            bit [7:0]  b;
            bit [7:0]  t;
            int        n;
            s = seed;
            for (n = 0; n < 3; n++)
            begin
                s = s ^ (s >> 30);
                s = s * 32'h6C07_8965 + 32'(n + 1);
                xs_state[n] = s;
            end
            xs_state[3] = 32'h03DF_95B3;
            for (n = 0; n < 256; n++)
                perm[n] = 8'(n);
            for (n = 0; n < ssk_pkg::SHUFFLE_ROUNDS; n++)
            begin
                x = xs_state[0];
                y = xs_state[3];
                xs_state[0] = xs_state[1];
                xs_state[1] = xs_state[2];
                xs_state[2] = xs_state[3];
                x = x ^ (x << 11);
                x = x ^ (x >> 8);
                y = y ^ (y >> 19);
                xs_state[3] = x ^ y;
                lo = xs_state[3][7:0];
                hi = xs_state[3][15:8];
                if (lo != hi)
                begin
                    a = perm[lo];
                    b = perm[hi];
                    t = perm[a];
                    perm[a] = perm[b];
                    perm[b] = t;
                end
            end
            pos = 16'h0000;
            built = 1'b1;
            rebuilds++;
        endfunction

        // Accepted input byte: work out its ciphertext byte
        function void note_input(bit [7:0] data, bit restart);
            bit [31:0] ks_idx;
            if (restart || !built)
                rebuild_perm();
            if (pos[7:0] == 8'h00)
            begin
                prime_key = key_primes[perm[pos[15:8]]];
                key_loads++;
            end
            ks_idx = (32'(prime_key) * (32'(pos) + 32'd1)) & 32'hFF;
            expected_bytes.push_back(data ^ perm[ks_idx[7:0]]);
            pos = pos + 16'd1;
            items++;
        endfunction

        // Accepted output byte against the oldest expectation
        function void check_result(bit [7:0] actual);
            bit [7:0] want;
            if (expected_bytes.size() == 0)
            begin
                $error("out_byte: expected none, actual %02h", actual);
                errors++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (want != actual)
                begin
                    $error("out_byte mismatch: expected %02h, actual %02h", want, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = 32'h0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        first = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;

    cipher_scoreboard board;
    bit send_idle_en = 1'b0;
    bit recv_idle_en = 1'b0;
    int hold_cycles = 0;
    int cycle_count = 0;

    seeded_shuffle_keystream_xor_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .first       (first),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte)
    );

    always #2 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_byte);
    end

    // Receiver stall: one long hold-off on request, else random bursts
    always
    begin
        @(posedge clk);
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            repeat (hold_cycles) @(posedge clk);
            hold_cycles = 0;
            out_stall <= 1'b0;
        end
        else if (recv_idle_en && $urandom_range(0, 3) == 0)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    // Offer one item and hold it until accepted
    task automatic send_byte(input bit [7:0] data, input bit restart);
        if (send_idle_en && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= data;
        first     <= restart;
        do @(posedge clk); while (in_stall);
        board.note_input(data, restart);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    task automatic write_seed(input bit [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.seed = value;
        board.seed_writes++;
    endtask

    initial
    begin
        int        seg;
        int        n;
        int        seg_len;
        bit [31:0] seg_seed;
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;

        // Reset seed; very first item has first low but must still build the table
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        // Explicit restarts mid-buffer on two bytes back to back
        send_byte(8'h3C, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);

        // New seed mid-buffer: old table stays until the next restart
        drain_results();
        write_seed(32'hFFFF_FFFF);
        send_byte(8'h11, 1'b0);
        send_byte(8'hEE, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        drain_results();
        write_seed(32'h0000_0000);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h3C, 1'b0);
        drain_results();
        write_seed(32'h8000_0001);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);

        // Random buffers, each with its own seed written first
        for (seg = 0; seg < 7; seg++)
        begin
            drain_results();
            case (seg)
                0: seg_seed = 32'h0000_0001;
                1: seg_seed = 32'h7FFF_FFFF;
                2: seg_seed = 32'hFFFF_FFFF;
                default: seg_seed = $urandom();
            endcase
            write_seed(seg_seed);
            send_idle_en = (seg != 1 && seg != 3);
            recv_idle_en = (seg % 3 != 2);
            seg_len = $urandom_range(100, 140);
            for (n = 0; n < seg_len; n++)
            begin
                // Long receiver hold-off while items keep coming
                if (seg == 3 && n == 20)
                    hold_cycles = 400;
                send_byte(8'($urandom_range(0, 255)),
                          (n == 0 && seg != 4) || $urandom_range(0, 299) == 0);
            end
        end

        // Closing buffer with no idling, long enough to cross a key reload
        drain_results();
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        for (n = 0; n < 300; n++)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        drain_results();
        repeat (50) @(posedge clk);

        $display("Covered %0d items, %0d table builds, %0d seed writes, %0d key loads",
                 board.items, board.rebuilds, board.seed_writes, board.key_loads);
        $display("Random idling on both sides, one long output hold-off, %0d mismatches",
                 board.errors);
        if (board.errors == 0 && board.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
